// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ----- rtl/scca_pkg.sv -----
// ----------------------------------------------------------------------------
// Size class chunk allocator package
// Shared constants, types and the class size table.
// ----------------------------------------------------------------------------
package scca_pkg;
  localparam int NCLASS = 10;
  localparam int FRAMES_DEF = 1024;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int ADDR_W = 22;
  localparam int GRAN_W = 18;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NOT_MANAGED = 2'd2;

  typedef logic [3:0] cls_t;

  function automatic logic [12:0] class_bytes(input cls_t c);
    logic [12:0] r;
    begin
      unique case (c)
        4'd0: r = 13'h10;
        4'd1: r = 13'h20;
        4'd2: r = 13'h30;
        4'd3: r = 13'h40;
        4'd4: r = 13'h60;
        4'd5: r = 13'h80;
        4'd6: r = 13'hc0;
        4'd7: r = 13'h100;
        4'd8: r = 13'h400;
        default: r = 13'h1000;
      endcase
      return r;
    end
  endfunction

  function automatic cls_t pick_class(input logic [12:0] s);
    cls_t r;
    begin
      if (s <= 13'h10) r = 4'd0;
      else if (s <= 13'h20) r = 4'd1;
      else if (s <= 13'h30) r = 4'd2;
      else if (s <= 13'h40) r = 4'd3;
      else if (s <= 13'h60) r = 4'd4;
      else if (s <= 13'h80) r = 4'd5;
      else if (s <= 13'hc0) r = 4'd6;
      else if (s <= 13'h100) r = 4'd7;
      else if (s <= 13'h400) r = 4'd8;
      else r = 4'd9;
      return r;
    end
  endfunction

  // Offset rounded down to a chunk boundary; 0x30, 0x60, 0xc0 divide by three
  // with a reciprocal multiplication.
  function automatic logic [11:0] round_off(input cls_t c, input logic [11:0] o);
    logic [11:0] r;
    logic [6:0] q;
    begin
      q = '0;
      r = '0;
      unique case (c)
        4'd0: r = {o[11:4], 4'd0};
        4'd1: r = {o[11:5], 5'd0};
        4'd3: r = {o[11:6], 6'd0};
        4'd5: r = {o[11:7], 7'd0};
        4'd7: r = {o[11:8], 8'd0};
        4'd8: r = {o[11:10], 10'd0};
        4'd9: r = '0;
        4'd2: begin
          q = 7'(({9'd0, o[11:4]} * 17'd171) >> 9);
          r = 12'({5'd0, q} * 12'd48);
        end
        4'd4: begin
          q = 7'(({10'd0, o[11:5]} * 17'd171) >> 9);
          r = 12'({5'd0, q} * 12'd96);
        end
        default: begin
          q = 7'(({7'd0, o[11:6]} * 13'd86) >> 8);
          r = 12'({5'd0, q} * 12'd192);
        end
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic start;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
  } ctl_sts_t;
endpackage

// ----- rtl/scca_if.sv -----
// ----------------------------------------------------------------------------
// Allocator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scca_req_if;
  logic valid;
  logic ready;
  logic mode;
  logic [12:0] req_size;
  logic [21:0] chunk_addr;
  logic [9:0] fresh_frame;
  modport source(output valid, mode, req_size, chunk_addr, fresh_frame, input ready);
  modport sink(input valid, mode, req_size, chunk_addr, fresh_frame, output ready);
endinterface

interface scca_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [21:0] result_addr;
  logic took_frame;
  logic [3:0] size_class;
  modport source(output valid, status, result_addr, took_frame, size_class, input ready);
  modport sink(input valid, status, result_addr, took_frame, size_class, output ready);
endinterface

// ----- rtl/scca_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one request: lookup cycle, commit cycle, then result hold.
// ----------------------------------------------------------------------------
module scca_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output scca_pkg::ctl_cmd_t cmd
);
  import scca_pkg::*;
  typedef enum logic [1:0] {IDLE, LOOK, DONE} state_t;
  state_t state;

  assign in_ready = (state == IDLE) || (state == DONE && out_ready);
  assign out_valid = (state == DONE);
  assign cmd.start = in_valid && in_ready;
  assign cmd.commit = (state == LOOK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: if (in_valid) state <= LOOK;
        LOOK: state <= DONE;
        DONE: if (out_ready) state <= in_valid ? LOOK : IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/scca_dp.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Frame table, link memory, class stacks and carve pointers.
// ----------------------------------------------------------------------------
module scca_dp #(
  parameter int FRAMES = scca_pkg::FRAMES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  scca_pkg::ctl_cmd_t cmd,
  input  logic mode,
  input  logic [12:0] req_size,
  input  logic [21:0] chunk_addr,
  input  logic [9:0] fresh_frame,
  output logic [1:0] status,
  output logic [21:0] result_addr,
  output logic took_frame,
  output logic [3:0] size_class
);
  import scca_pkg::*;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Split flags are cleared by a sweep after reset, one frame per cycle.
  logic split_mem [FRAMES];
  logic [3:0] class_mem [FRAMES];
  logic [21:0] link_mem [2**GRAN_W];
  logic [FW:0] clr_cnt;
  logic clearing;

  logic [21:0] head [NCLASS];
  logic [NCLASS-1:0] svalid;
  logic [9:0] cframe [NCLASS];
  logic [12:0] coff [NCLASS];

  logic r_mode;
  logic r_big;
  cls_t r_cls;
  logic [21:0] r_addr;
  logic [9:0] r_fresh;
  logic r_frame_ok;
  logic split_q;
  logic [3:0] fcls_q;
  logic [21:0] link_q;

  assign clearing = (clr_cnt < (FW+1)'(FRAMES));

  logic [16:0] a_frame;
  logic [FW-1:0] fidx;
  assign a_frame = 17'(chunk_addr[21:12]);
  assign fidx = FW'(chunk_addr[21:12]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Stage 1: capture request, read frame table and link of the class head.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_mode <= mode;
      r_big <= (req_size > 13'd4096);
      r_cls <= pick_class(req_size);
      r_addr <= chunk_addr;
      r_fresh <= fresh_frame;
      r_frame_ok <= (a_frame < 17'(FRAMES));
      split_q <= split_mem[fidx];
      fcls_q <= class_mem[fidx];
      link_q <= link_mem[head[pick_class(req_size)][21:4]];
    end
  end

  cls_t fc;
  logic [12:0] sz;
  logic [11:0] base;
  logic [21:0] push_addr;
  logic free_ok;
  cls_t ac;
  logic [12:0] asz;
  logic refill;
  logic [21:0] carve_addr;
  logic [12:0] cur_off;
  logic [9:0] cur_frame;
  logic [16:0] fresh_w;

  always_comb begin
    fc = (fcls_q > 4'd9) ? 4'(fcls_q - 4'd10) : fcls_q;
    sz = class_bytes(fc);
    base = round_off(fc, r_addr[11:0]);
    push_addr = {r_addr[21:12], base};
    free_ok = r_frame_ok && split_q && ((13'(base) + sz) <= 13'd4096);
    ac = r_cls;
    asz = class_bytes(ac);
    refill = !svalid[ac] && ((14'(coff[ac]) + 14'(asz)) > 14'd4096);
    cur_off = refill ? 13'd0 : coff[ac];
    cur_frame = refill ? r_fresh : cframe[ac];
    carve_addr = {cur_frame, cur_off[11:0]};
    fresh_w = 17'(r_fresh);
  end

  // Stage 2: commit state updates and register the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= '0;
      for (int i = 0; i < NCLASS; i++) coff[i] <= 13'd4096;
    end else if (cmd.commit) begin
      status <= ST_OK;
      result_addr <= '0;
      took_frame <= 1'b0;
      size_class <= '0;
      if (!r_mode) begin
        if (r_big) begin
          status <= ST_TOO_LARGE;
        end else begin
          size_class <= ac;
          if (svalid[ac]) begin
            result_addr <= head[ac];
            if (link_q[0]) svalid[ac] <= 1'b0;
            else head[ac] <= link_q;
          end else begin
            result_addr <= carve_addr;
            took_frame <= refill;
            cframe[ac] <= cur_frame;
            coff[ac] <= cur_off + asz;
          end
        end
      end else if (!free_ok) begin
        status <= ST_NOT_MANAGED;
      end else begin
        size_class <= fc;
        head[fc] <= push_addr;
        svalid[fc] <= 1'b1;
      end
    end
  end

  // Memory writes: clearing sweep, frame table on refill, link on push.
  always_ff @(posedge clk) begin
    if (clearing) begin
      split_mem[clr_cnt[FW-1:0]] <= 1'b0;
    end else if (cmd.commit && !r_mode && !r_big && !svalid[ac] && refill &&
                 fresh_w < 17'(FRAMES)) begin
      split_mem[FW'(r_fresh)] <= 1'b1;
    end
    if (cmd.commit && !r_mode && !r_big && !svalid[ac] && refill &&
        fresh_w < 17'(FRAMES)) begin
      class_mem[FW'(r_fresh)] <= ac;
    end
    if (cmd.commit && r_mode && free_ok) begin
      link_mem[push_addr[21:4]] <= svalid[fc] ? head[fc] : 22'd1;
    end
  end
endmodule

// ----- rtl/size_class_chunk_allocator_unit.sv -----
// A request's result is valid in the DONE state, which the controller reaches
// through LOOK after acceptance. Requests do not overlap: a new one is not
// accepted before the previous result is taken, due to the read-then-write of
// the link memory and frame table (lookup, then commit). After reset a sweep
// clears the split flags of all FRAMES frames, during which no request is accepted.
// ----------------------------------------------------------------------------
// Size class chunk allocator
// Top level: joins the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module size_class_chunk_allocator_unit #(
  parameter int FRAMES = scca_pkg::FRAMES_DEF
) (
  input logic clk,
  input logic rst,
  scca_req_if.sink req,
  scca_rsp_if.source rsp
);
  import scca_pkg::*;
  ctl_cmd_t cmd;
  logic c_in_ready;
  logic busy;

  // The sweep counter lives in the datapath; mirror it here for gating.
  logic [$clog2(FRAMES+1):0] sweep;
  always_ff @(posedge clk) begin
    if (rst) sweep <= '0;
    else if (busy) sweep <= sweep + 1'b1;
  end
  assign busy = (sweep < ($clog2(FRAMES+1)+1)'(FRAMES));

  logic gated_valid;
  assign gated_valid = req.valid && !busy;
  assign req.ready = c_in_ready && !busy;

  scca_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(gated_valid), .in_ready(c_in_ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd(cmd)
  );

  scca_dp #(.FRAMES(FRAMES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mode(req.mode), .req_size(req.req_size),
    .chunk_addr(req.chunk_addr), .fresh_frame(req.fresh_frame),
    .status(rsp.status), .result_addr(rsp.result_addr),
    .took_frame(rsp.took_frame), .size_class(rsp.size_class)
  );

  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, busy, !req.ready)
  `ASSERT_NEXT(a_commit_after_start, clk, rst, cmd.start, cmd.commit)
  `ASSERT_IMPLIES(a_class_range, clk, rst, rsp.valid, rsp.size_class <= 4'd9)
endmodule
